// ----- rtl/ipslr_pkg.sv -----
`default_nettype none
package ipslr_pkg;

  localparam logic [30:0] BOUND_RESET = 31'd65536;
  localparam logic [30:0] BOUND_MAX   = 31'h7FFF_FFFF;
  localparam logic [1:0]  TEST_LAST   = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM_GO,
    ST_SUM_MUL,
    ST_SUM_WB,
    ST_DM_GO,
    ST_DM_MUL,
    ST_DM_WB,
    ST_TST_GO,
    ST_TST_MUL,
    ST_TST_WB,
    ST_DIV,
    ST_DIV_WB,
    ST_FIN
  } state_t;

  // Operand set loaded into the shift-add multiplier.
  typedef enum logic [1:0] {
    MOP_SUM,
    MOP_DM,
    MOP_TEST
  } mop_t;

  // Register that takes the finished multiplier or divider result.
  typedef enum logic [1:0] {
    WB_NONE,
    WB_SUM,
    WB_DMULT,
    WB_BOUND
  } wb_t;

  typedef struct packed {
    logic       accept;
    logic       mul_start;
    mop_t       mop;
    logic       mul_step;
    logic       div_start;
    logic       div_step;
    wb_t        wb;
    logic       bound_zero;
    logic [1:0] idx;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic mul_last;
    logic div_last;
    logic hit;
    logic same_sign;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// ----- rtl/ipslr_ctrl.sv -----
`default_nettype none
module ipslr_ctrl (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  ipslr_pkg::status_t st,
  output ipslr_pkg::cmd_t    cmd
);

  ipslr_pkg::state_t state_r, state_nxt;
  logic [1:0]        idx_r, idx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ipslr_pkg::ST_IDLE;
      idx_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  assign in_stall = (state_r != ipslr_pkg::ST_IDLE);

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    cmd            = '0;
    cmd.mop        = ipslr_pkg::MOP_SUM;
    cmd.wb         = ipslr_pkg::WB_NONE;
    cmd.idx        = idx_r;
    unique case (state_r)
      ipslr_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          idx_nxt    = 2'd0;
          state_nxt  = ipslr_pkg::ST_SUM_GO;
        end
      end
      ipslr_pkg::ST_SUM_GO: begin
        cmd.mul_start = 1'b1;
        cmd.mop       = ipslr_pkg::MOP_SUM;
        state_nxt     = ipslr_pkg::ST_SUM_MUL;
      end
      ipslr_pkg::ST_SUM_MUL: begin
        cmd.mul_step = 1'b1;
        if (st.mul_last) state_nxt = ipslr_pkg::ST_SUM_WB;
      end
      ipslr_pkg::ST_SUM_WB: begin
        cmd.wb    = ipslr_pkg::WB_SUM;
        state_nxt = ipslr_pkg::ST_DM_GO;
      end
      ipslr_pkg::ST_DM_GO: begin
        cmd.mul_start = 1'b1;
        cmd.mop       = ipslr_pkg::MOP_DM;
        state_nxt     = ipslr_pkg::ST_DM_MUL;
      end
      ipslr_pkg::ST_DM_MUL: begin
        cmd.mul_step = 1'b1;
        if (st.mul_last) state_nxt = ipslr_pkg::ST_DM_WB;
      end
      ipslr_pkg::ST_DM_WB: begin
        cmd.wb = ipslr_pkg::WB_DMULT;
        if (idx_r == 2'd0) begin
          idx_nxt   = 2'd1;
          state_nxt = ipslr_pkg::ST_SUM_GO;
        end else begin
          idx_nxt   = 2'd0;
          state_nxt = ipslr_pkg::ST_TST_GO;
        end
      end
      ipslr_pkg::ST_TST_GO: begin
        cmd.mul_start = 1'b1;
        cmd.mop       = ipslr_pkg::MOP_TEST;
        state_nxt     = ipslr_pkg::ST_TST_MUL;
      end
      ipslr_pkg::ST_TST_MUL: begin
        cmd.mul_step = 1'b1;
        if (st.mul_last) state_nxt = ipslr_pkg::ST_TST_WB;
      end
      ipslr_pkg::ST_TST_WB: begin
        if (st.hit && !st.same_sign) begin
          cmd.div_start = 1'b1;
          state_nxt     = ipslr_pkg::ST_DIV;
        end else begin
          cmd.bound_zero = st.hit;
          if (idx_r == ipslr_pkg::TEST_LAST) begin
            state_nxt = ipslr_pkg::ST_FIN;
          end else begin
            idx_nxt   = idx_r + 2'd1;
            state_nxt = ipslr_pkg::ST_TST_GO;
          end
        end
      end
      ipslr_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) state_nxt = ipslr_pkg::ST_DIV_WB;
      end
      ipslr_pkg::ST_DIV_WB: begin
        cmd.wb = ipslr_pkg::WB_BOUND;
        if (idx_r == ipslr_pkg::TEST_LAST) begin
          state_nxt = ipslr_pkg::ST_FIN;
        end else begin
          idx_nxt   = idx_r + 2'd1;
          state_nxt = ipslr_pkg::ST_TST_GO;
        end
      end
      ipslr_pkg::ST_FIN: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ipslr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ipslr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/ipslr_dp.sv -----
`default_nettype none
module ipslr_dp #(
  parameter int FRAC_BITS  = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  ipslr_pkg::cmd_t           cmd,
  output ipslr_pkg::status_t        st,
  input  wire                       cfg_wr_en,
  input  wire                [30:0] cfg_wr_data,
  input  wire                       in_sweep_start,
  input  wire signed         [31:0] in_proj_step,
  input  wire signed         [31:0] in_resid_d_lo,
  input  wire signed         [31:0] in_resid_d_hi,
  input  wire signed         [31:0] in_resid_m_lo,
  input  wire signed         [31:0] in_resid_m_hi,
  input  wire signed         [31:0] in_slack_lo,
  input  wire signed         [31:0] in_slack_hi,
  input  wire signed         [31:0] in_inv_slack_lo,
  input  wire signed         [31:0] in_inv_slack_hi,
  input  wire signed         [31:0] in_mult_lo,
  input  wire signed         [31:0] in_mult_hi,
  output logic                      out_valid,
  input  wire                       out_stall,
  output logic signed        [31:0] out_dslack_lo,
  output logic signed        [31:0] out_dslack_hi,
  output logic signed        [31:0] out_dmult_lo,
  output logic signed        [31:0] out_dmult_hi,
  output logic               [30:0] out_step_bound
);

  localparam int W    = DATA_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int MW   = (W > 32) ? W : 32;
  localparam int PW   = 2 * MW;
  localparam int SW   = PW + 2;
  localparam int DW   = W + F;
  localparam int CW   = PW + F + 2;
  localparam int LEN  = (DW > MW) ? DW : MW;
  localparam int CNTW = $clog2(LEN);

  localparam logic signed [SW-1:0] VMAX  = signed'((SW'(1) << (W - 1)) - SW'(1));
  localparam logic signed [SW-1:0] VMIN  = -VMAX - SW'(1);
  localparam logic signed [SW-1:0] OMAX  = signed'(SW'(32'h7FFF_FFFF));
  localparam logic signed [SW-1:0] OMIN  = -OMAX - SW'(1);
  localparam logic        [PW:0]   HALF  = (PW + 1)'(1) << (F - 1);

  function automatic logic signed [W-1:0] sat(input logic signed [SW-1:0] x);
    if (x > VMAX) begin
      sat = VMAX[W-1:0];
    end else if (x < VMIN) begin
      sat = VMIN[W-1:0];
    end else begin
      sat = x[W-1:0];
    end
  endfunction

  function automatic logic signed [W-1:0] sadd(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    sadd = sat(SW'(a) + SW'(b));
  endfunction

  function automatic logic signed [W-1:0] sneg(input logic signed [W-1:0] a);
    sneg = sat(-SW'(a));
  endfunction

  function automatic logic [W-1:0] magw(input logic signed [W-1:0] a);
    magw = a[W-1] ? W'(~a + 1'b1) : W'(a);
  endfunction

  // Round to nearest at the binary point, ties away from zero, then saturate.
  function automatic logic signed [W-1:0] qround(input logic [PW-1:0] p,
                                                 input logic neg);
    logic [PW:0]           sum;
    logic [PW-F:0]         m;
    logic signed [SW-1:0]  ms;
    sum = {1'b0, p} + HALF;
    m   = sum[PW:F];
    ms  = signed'(SW'(m));
    qround = sat(neg ? -ms : ms);
  endfunction

  function automatic logic signed [31:0] out32(input logic signed [W-1:0] a);
    logic signed [SW-1:0] x;
    x = SW'(a);
    if (x > OMAX) begin
      out32 = 32'sh7FFF_FFFF;
    end else if (x < OMIN) begin
      out32 = 32'sh8000_0000;
    end else begin
      out32 = x[31:0];
    end
  endfunction

  // Item operands and intermediate results.
  logic signed [W-1:0] dt_lo_r, dt_hi_r, rm_lo_r, rm_hi_r;
  logic signed [W-1:0] t_lo_r, t_hi_r, tinv_lo_r, tinv_hi_r;
  logic signed [W-1:0] lam_lo_r, lam_hi_r, dl_lo_r, dl_hi_r, x_r;
  logic        [30:0]  bound_r, init_r;

  // Shift-add multiplier.
  logic [PW-1:0]   ma_r, acc_r;
  logic [MW-1:0]   mb_r;
  logic            neg_r;
  logic [CNTW-1:0] cnt_r;

  // Restoring divider.
  logic [DW-1:0] dv_r;
  logic [W-1:0]  den_r, rem_r;
  logic [31:0]   q_r;
  logic          sticky_r;

  logic                out_valid_r;

  logic signed [W-1:0] p_in, dt_lo_in, dt_hi_in;
  logic signed [W-1:0] sel_lam, sel_dt, sel_tinv, sel_rm, sel_v, sel_d;
  logic        [MW-1:0] op_a, op_b;
  logic                op_neg;
  logic signed [W-1:0] prod_q;
  logic signed [CW-1:0] lhs, rhs;
  logic [W:0]          r2;
  logic                ge;
  logic [W-1:0]        rem_nxt;
  logic [31:0]         q_nxt;
  logic                sticky_nxt;

  assign p_in     = sat(SW'(in_proj_step));
  assign dt_lo_in = sadd(p_in, sneg(sat(SW'(in_resid_d_lo))));
  assign dt_hi_in = sadd(sat(SW'(in_resid_d_hi)), sneg(p_in));

  always_comb begin
    sel_lam  = cmd.idx[0] ? lam_hi_r  : lam_lo_r;
    sel_dt   = cmd.idx[0] ? dt_hi_r   : dt_lo_r;
    sel_tinv = cmd.idx[0] ? tinv_hi_r : tinv_lo_r;
    sel_rm   = cmd.idx[0] ? rm_hi_r   : rm_lo_r;
    unique case (cmd.idx)
      2'd0: begin
        sel_v = lam_lo_r;
        sel_d = dl_lo_r;
      end
      2'd1: begin
        sel_v = lam_hi_r;
        sel_d = dl_hi_r;
      end
      2'd2: begin
        sel_v = t_lo_r;
        sel_d = dt_lo_r;
      end
      default: begin
        sel_v = t_hi_r;
        sel_d = dt_hi_r;
      end
    endcase
  end

  always_comb begin
    unique case (cmd.mop)
      ipslr_pkg::MOP_SUM: begin
        op_a   = MW'(magw(sel_lam));
        op_b   = MW'(magw(sel_dt));
        op_neg = sel_lam[W-1] ^ sel_dt[W-1];
      end
      ipslr_pkg::MOP_DM: begin
        op_a   = MW'(magw(sel_tinv));
        op_b   = MW'(magw(x_r));
        op_neg = sel_tinv[W-1] ^ x_r[W-1];
      end
      default: begin
        op_a   = MW'(bound_r);
        op_b   = MW'(magw(sel_d));
        op_neg = 1'b0;
      end
    endcase
  end

  assign prod_q = qround(acc_r, neg_r);

  // Exact ratio test: -alpha*d > v, with v scaled to the product's binary point.
  always_comb begin
    lhs = signed'(CW'(acc_r));
    if (!sel_d[W-1]) lhs = -lhs;
    rhs = signed'(CW'({magw(sel_v), {F{1'b0}}}));
    if (sel_v[W-1]) rhs = -rhs;
  end

  always_comb begin
    r2         = {rem_r, dv_r[DW-1]};
    ge         = (r2 >= {1'b0, den_r});
    rem_nxt    = ge ? W'(r2 - {1'b0, den_r}) : W'(r2);
    q_nxt      = {q_r[30:0], ge};
    sticky_nxt = sticky_r | q_r[31] | q_nxt[31];
  end

  assign st.mul_last  = (cnt_r == CNTW'(MW - 1));
  assign st.div_last  = (cnt_r == CNTW'(DW - 1));
  assign st.hit       = (sel_d != '0) && (lhs > rhs);
  assign st.same_sign = (sel_v[W-1] == sel_d[W-1]);
  assign st.out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r      <= ipslr_pkg::BOUND_RESET;
      bound_r     <= ipslr_pkg::BOUND_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) init_r <= cfg_wr_data;
      if (cmd.accept && in_sweep_start) begin
        bound_r <= init_r;
      end else if (cmd.bound_zero) begin
        bound_r <= '0;
      end else if (cmd.wb == ipslr_pkg::WB_BOUND) begin
        bound_r <= sticky_r ? ipslr_pkg::BOUND_MAX : q_r[30:0];
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      dt_lo_r   <= dt_lo_in;
      dt_hi_r   <= dt_hi_in;
      rm_lo_r   <= sat(SW'(in_resid_m_lo));
      rm_hi_r   <= sat(SW'(in_resid_m_hi));
      t_lo_r    <= sat(SW'(in_slack_lo));
      t_hi_r    <= sat(SW'(in_slack_hi));
      tinv_lo_r <= sat(SW'(in_inv_slack_lo));
      tinv_hi_r <= sat(SW'(in_inv_slack_hi));
      lam_lo_r  <= sat(SW'(in_mult_lo));
      lam_hi_r  <= sat(SW'(in_mult_hi));
    end

    unique case (cmd.wb)
      ipslr_pkg::WB_SUM:   x_r <= sadd(prod_q, sel_rm);
      ipslr_pkg::WB_DMULT: begin
        if (cmd.idx[0]) dl_hi_r <= sneg(prod_q);
        else            dl_lo_r <= sneg(prod_q);
      end
      default: ;
    endcase

    if (cmd.mul_start) begin
      ma_r  <= PW'(op_a);
      mb_r  <= op_b;
      acc_r <= '0;
      neg_r <= op_neg;
      cnt_r <= '0;
    end else if (cmd.mul_step) begin
      acc_r <= acc_r + (mb_r[0] ? ma_r : '0);
      ma_r  <= ma_r << 1;
      mb_r  <= mb_r >> 1;
      cnt_r <= cnt_r + 1'b1;
    end else if (cmd.div_start) begin
      dv_r     <= {magw(sel_v), {F{1'b0}}};
      den_r    <= magw(sel_d);
      rem_r    <= '0;
      q_r      <= '0;
      sticky_r <= 1'b0;
      cnt_r    <= '0;
    end else if (cmd.div_step) begin
      dv_r     <= dv_r << 1;
      rem_r    <= rem_nxt;
      q_r      <= q_nxt;
      sticky_r <= sticky_nxt;
      cnt_r    <= cnt_r + 1'b1;
    end

    if (cmd.load_out) begin
      out_dslack_lo  <= out32(dt_lo_r);
      out_dslack_hi  <= out32(dt_hi_r);
      out_dmult_lo   <= out32(dl_lo_r);
      out_dmult_hi   <= out32(dl_hi_r);
      out_step_bound <= bound_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// ----- rtl/ip_step_length_ratio_test_core.sv -----
`default_nettype none
// Fraction-to-boundary step length engine for an interior-point solver. Each input
// transaction carries one inequality constraint: the projected primal step, and for
// the lower and upper side the primal and complementarity residuals, the slack, its
// inverse and the multiplier, all signed fixed point with FRAC_BITS fraction bits.
// The block returns one result transaction per input: the slack steps, the
// multiplier steps (saturated) and the running step bound after four ratio tests.
// A set sweep_start bit reloads the bound from the initial_step register, which the
// user must write through cfg_wr_en/cfg_wr_data only while the block is idle; the
// block itself does not enforce this. Items are handled one at a time; a finished
// result sits in an output register, so the next input transaction is taken while
// the previous result is still stalled. The cost of one item is set by a single
// shift-add multiplier (one product bit per cycle over MW = max(DATA_WIDTH, 32)
// bits) and a restoring divider (one quotient bit per cycle over DATA_WIDTH +
// FRAC_BITS bits). An item makes eight multiplier passes (two products for each
// multiplier step and one for each of the four ratio tests), plus one division
// for each ratio test that hits with a positive quotient. The input is accepted
// before the first pass and the result is handed off after the last; the hand-off
// waits while the previous result is still stalled in the output register.
module ip_step_length_ratio_test_core #(
  parameter int FRAC_BITS  = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                cfg_wr_en,
  input  wire         [30:0] cfg_wr_data,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire                in_sweep_start,
  input  wire signed  [31:0] in_proj_step,
  input  wire signed  [31:0] in_resid_d_lo,
  input  wire signed  [31:0] in_resid_d_hi,
  input  wire signed  [31:0] in_resid_m_lo,
  input  wire signed  [31:0] in_resid_m_hi,
  input  wire signed  [31:0] in_slack_lo,
  input  wire signed  [31:0] in_slack_hi,
  input  wire signed  [31:0] in_inv_slack_lo,
  input  wire signed  [31:0] in_inv_slack_hi,
  input  wire signed  [31:0] in_mult_lo,
  input  wire signed  [31:0] in_mult_hi,
  output logic               out_valid,
  input  wire                out_stall,
  output logic signed [31:0] out_dslack_lo,
  output logic signed [31:0] out_dslack_hi,
  output logic signed [31:0] out_dmult_lo,
  output logic signed [31:0] out_dmult_hi,
  output logic        [30:0] out_step_bound
);

  // Commands from the sequencer and status back from the datapath.
  ipslr_pkg::cmd_t    cmd;
  ipslr_pkg::status_t st;

  // The sequencer walks the item through the lower and upper multiplier steps,
  // then the four ratio tests, and finally waits for the output register.
  ipslr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // The datapath holds the operands, the shared multiplier and divider, the
  // running bound and the output register.
  ipslr_dp #(
    .FRAC_BITS  (FRAC_BITS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .st              (st),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_sweep_start  (in_sweep_start),
    .in_proj_step    (in_proj_step),
    .in_resid_d_lo   (in_resid_d_lo),
    .in_resid_d_hi   (in_resid_d_hi),
    .in_resid_m_lo   (in_resid_m_lo),
    .in_resid_m_hi   (in_resid_m_hi),
    .in_slack_lo     (in_slack_lo),
    .in_slack_hi     (in_slack_hi),
    .in_inv_slack_lo (in_inv_slack_lo),
    .in_inv_slack_hi (in_inv_slack_hi),
    .in_mult_lo      (in_mult_lo),
    .in_mult_hi      (in_mult_hi),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_dslack_lo   (out_dslack_lo),
    .out_dslack_hi   (out_dslack_hi),
    .out_dmult_lo    (out_dmult_lo),
    .out_dmult_hi    (out_dmult_hi),
    .out_step_bound  (out_step_bound)
  );

endmodule
`default_nettype wire
